FILE: rtl/isadd_pkg.sv
package isadd_pkg;

   localparam int CMD_W   = 2;
   localparam int INDEX_W = 14;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request and launch the table read
      logic commit;    // update the entry and load the result register
   } ctrl_type;

endpackage

FILE: rtl/indexed_scatter_add_unit.sv
// Indexed accumulate engine over a table of TABLE_DEPTH signed Q15.24 words of
// VALUE_WIDTH bits held in one single-port memory. Each beat is a write, an
// add or a read of one entry and returns exactly one beat with the entry after
// the command; adds saturate to the signed limits and flag it in rsp_tuser.
// An item runs as the registered table read at request time, then the add,
// saturation and write-back, which also load the result register; a result
// held by rsp_tready low stalls the write-back of the next item. The next
// request is taken while a result waits.
// The table is not cleared at reset: an entry must be written before it is
// read or added to. Indexes at or past TABLE_DEPTH are ignored and return zero.
module indexed_scatter_add_unit #(
   parameter int TABLE_DEPTH = 16384,
   parameter int VALUE_WIDTH = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // index, value, zero fill
   input  logic [((isadd_pkg::INDEX_W+VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   // cmd
   input  logic [isadd_pkg::CMD_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_value, zero fill
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   // saturated
   output logic [0:0]                        rsp_tuser
);

   localparam int RSP_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   isadd_pkg::ctrl_type             ctrl;
   logic [isadd_pkg::INDEX_W-1:0]   req_index;
   logic signed [VALUE_WIDTH-1:0]   req_value;
   logic [VALUE_WIDTH-1:0]          entry_value;
   logic                            saturated;

   assign req_index = req_tdata[isadd_pkg::INDEX_W-1:0];
   assign req_value = req_tdata[isadd_pkg::INDEX_W +: VALUE_WIDTH];

   isadd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   isadd_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .ctrl            (ctrl),
      .req_cmd         (req_tuser),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_entry_value (entry_value),
      .rsp_saturated   (saturated)
   );

   assign rsp_tdata = RSP_DATA_W'(entry_value);
   assign rsp_tuser = saturated;

`ifndef SYNTHESIS
   a_no_capture_on_commit: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |-> !ctrl.commit)
      else $error("request taken while an item is being completed");

   a_busy_after_capture: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> !req_tready)
      else $error("request accepted while previous item still in flight");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_tvalid)
      else $error("completed item produced no result beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !ctrl.commit)
      else $error("result register overwritten while a beat waits");
`endif

endmodule

FILE: rtl/isadd_ctrl.sv
module isadd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output isadd_pkg::ctrl_type ctrl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic slot_free;

   assign req_tready   = (state_ff == ST_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign ctrl.capture = req_tvalid && req_tready;
   assign ctrl.commit  = (state_ff == ST_EXEC) && slot_free;
   assign rsp_tvalid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold here while the previous result has not been taken
            if (ctrl.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctrl.commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/isadd_dpath.sv
module isadd_dpath #(
   parameter int TABLE_DEPTH = 16384,
   parameter int VALUE_WIDTH = 40
) (
   input  logic                                clock,
   input  isadd_pkg::ctrl_type                 ctrl,
   input  logic [isadd_pkg::CMD_W-1:0]         req_cmd,
   input  logic [isadd_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   output logic [VALUE_WIDTH-1:0]              rsp_entry_value,
   output logic                                rsp_saturated
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EXT_W  = (ADDR_W > isadd_pkg::INDEX_W) ? ADDR_W : isadd_pkg::INDEX_W;
   localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);
   localparam logic signed [VALUE_WIDTH-1:0] MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];

   logic [EXT_W-1:0]              index_ext;
   logic [ADDR_W-1:0]             req_addr;
   logic                          req_in_range;

   logic [isadd_pkg::CMD_W-1:0]   cmd_ff;
   logic [ADDR_W-1:0]             addr_ff;
   logic                          in_range_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   logic signed [VALUE_WIDTH:0]   sum_wide;
   logic signed [VALUE_WIDTH-1:0] sum_sat;
   logic                          sum_clip;
   logic signed [VALUE_WIDTH-1:0] result_in;
   logic                          sat_in;
   logic                          table_we;

   logic [VALUE_WIDTH-1:0]        entry_ff;
   logic                          sat_ff;

   assign index_ext    = EXT_W'(req_index);
   assign req_addr     = index_ext[ADDR_W-1:0];
   assign req_in_range = (32'(req_index) < DEPTH_32);

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff      <= req_cmd;
         addr_ff     <= req_addr;
         in_range_ff <= req_in_range;
         value_ff    <= req_value;
         rd_data_ff  <= table_mem[req_addr];
      end
   end

   // true sum sign sits in the extra top bit
   assign sum_wide = {rd_data_ff[VALUE_WIDTH-1], rd_data_ff}
                   + {value_ff[VALUE_WIDTH-1], value_ff};
   assign sum_clip = sum_wide[VALUE_WIDTH] != sum_wide[VALUE_WIDTH-1];

   always_comb begin
      if (!sum_clip) begin
         sum_sat = sum_wide[VALUE_WIDTH-1:0];
      end else if (sum_wide[VALUE_WIDTH]) begin
         sum_sat = MIN_VAL;
      end else begin
         sum_sat = MAX_VAL;
      end
   end

   always_comb begin
      result_in = rd_data_ff;
      sat_in    = 1'b0;
      table_we  = 1'b0;
      case (cmd_ff)
         isadd_pkg::CMD_WRITE: begin
            result_in = value_ff;
            table_we  = 1'b1;
         end
         isadd_pkg::CMD_ADD: begin
            result_in = sum_sat;
            sat_in    = sum_clip;
            table_we  = 1'b1;
         end
         default: begin
            result_in = rd_data_ff;
         end
      endcase
      // index past the table: command dropped, zero result
      if (!in_range_ff) begin
         result_in = '0;
         sat_in    = 1'b0;
         table_we  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit && table_we) begin
         table_mem[addr_ff] <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         entry_ff <= result_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_entry_value = entry_ff;
   assign rsp_saturated   = sat_ff;

endmodule
